// ===== design/sal_pkg.sv =====
// ----------------------------------------------------------------------------
// sal_pkg: shared types and constants for the sorted array list
// Command codes, FSM states, widths and the per-cell control struct.
// ----------------------------------------------------------------------------
package sal_pkg;

    localparam int DEPTH   = 64;                  // number of cells
    localparam int VALUE_W = 32;                  // stored value width
    localparam int COUNT_W = $clog2(DEPTH + 1);   // entry count / position width
    localparam int CMD_W   = 3;
    localparam int CAP_W   = 7;                   // capacity register width
    localparam int IN_W    = 40;                  // s_tdata width
    localparam int OUT_W   = 24;                  // m_tdata width

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_REM_FIRST = 3'd1,
        CMD_REM_LAST  = 3'd2,
        CMD_REM_AT    = 3'd3,
        CMD_SEARCH    = 3'd4,
        CMD_CLEAR     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENCODE,
        ST_OUTPUT
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                      ins;     // insert this cycle
        logic                      rm;      // remove this cycle
        logic                      srch;    // search this cycle
        logic [COUNT_W-1:0]        rm_pos;  // 0-based slot being removed
        logic [COUNT_W-1:0]        count;   // entries in use before the word
        logic signed [VALUE_W-1:0] key;
    } cell_ctrl_t;

endpackage

// ===== design/sal_cell.sv =====
// ----------------------------------------------------------------------------
// sal_cell: one slot of the sorted list
// Holds one value, compares it with the broadcast key, shifts with neighbors.
// ----------------------------------------------------------------------------
module sal_cell (
    input  logic                               clk,
    input  logic [sal_pkg::COUNT_W-1:0]        idx,
    input  sal_pkg::cell_ctrl_t                ctrl,
    input  logic signed [sal_pkg::VALUE_W-1:0] left_value,
    input  logic                               left_gt,
    input  logic                               left_lt,
    input  logic signed [sal_pkg::VALUE_W-1:0] right_value,
    output logic signed [sal_pkg::VALUE_W-1:0] value,
    output logic                               gt,
    output logic                               lt,
    output logic                               hit
);

    logic signed [sal_pkg::VALUE_W-1:0] value_reg;
    logic signed [sal_pkg::VALUE_W-1:0] value_next;
    logic                               hit_reg;
    logic                               hit_next;
    logic                               in_use;

    assign in_use = idx < ctrl.count;
    assign gt     = in_use && (value_reg > ctrl.key);
    assign lt     = in_use && (value_reg < ctrl.key);
    assign value  = value_reg;
    assign hit    = hit_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            // entries above the insertion point move up one slot
            if (left_gt)
                value_next = left_value;
            else if (!in_use || gt)
                value_next = ctrl.key;
        end
        else if (ctrl.rm && (idx >= ctrl.rm_pos))
        begin
            value_next = right_value;
        end
        // lower bound hit: first slot that holds a value equal to the key
        hit_next = ctrl.srch && in_use && (value_reg == ctrl.key) && left_lt;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        hit_reg   <= hit_next;
    end

endmodule

// ===== design/sal_encoder.sv =====
// ----------------------------------------------------------------------------
// sal_encoder: search hit encoder
// Turns the one-hot cell hit vector into a 1-based position.
// ----------------------------------------------------------------------------
module sal_encoder (
    input  logic [sal_pkg::DEPTH-1:0]   hits,
    output logic [sal_pkg::COUNT_W-1:0] found_at,
    output logic                        any_hit
);

    always_comb
    begin
        found_at = '0;
        for (int i = 0; i < sal_pkg::DEPTH; i++)
        begin
            if (hits[i])
                found_at = found_at | sal_pkg::COUNT_W'(i + 1);
        end
        any_hit = |hits;
    end

endmodule

// ===== design/sorted_array_list.sv =====
// ----------------------------------------------------------------------------
// sorted_array_list: sorted list of signed values in a chain of cells
// Result: after s_tdata is accepted the FSM moves to ST_ENCODE, then to
// ST_OUTPUT, where m_tvalid is raised and held until m_tready; one word is
// in flight at a time, set by the cell update / hit encode / output sequence.
// Reset (rst_n, async, active low): list empty, capacity 64, FSM idle.
// Stored values are not cleared; slots at or above the count are never read.
// ----------------------------------------------------------------------------
module sorted_array_list (
    input  logic                         clk,
    input  logic                         rst_n,
    // input words
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sal_pkg::IN_W-1:0]     s_tdata,  // [31:0] value, [38:32] position
    input  logic [sal_pkg::CMD_W-1:0]    s_tuser,  // [2:0] command
    // result words
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sal_pkg::OUT_W-1:0]    m_tdata,  // [0] ok, [7:1] found_at,
                                                   // [14:8] entry_count,
                                                   // [15] is_full, [16] is_empty
    // capacity register write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sal_pkg::CAP_W-1:0]    cfg_data
);

    localparam logic [sal_pkg::COUNT_W-1:0] DEPTH_C = sal_pkg::COUNT_W'(sal_pkg::DEPTH);

    sal_pkg::state_t state_reg, state_next;

    logic [sal_pkg::CAP_W-1:0]   cap_reg;
    logic [sal_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        ok_reg, ok_next;
    logic [sal_pkg::OUT_W-1:0]   out_reg;

    // fields of the incoming word
    sal_pkg::cmd_t                      cmd;
    logic signed [sal_pkg::VALUE_W-1:0] in_value;
    logic [sal_pkg::COUNT_W-1:0]        in_pos;
    logic                               accept;

    // capacity clipped to the number of cells
    logic [sal_pkg::COUNT_W-1:0]        eff_cap;

    sal_pkg::cell_ctrl_t                ctrl;

    // chain wiring
    logic signed [sal_pkg::VALUE_W-1:0] cell_value [sal_pkg::DEPTH];
    logic [sal_pkg::DEPTH-1:0]          cell_gt;
    logic [sal_pkg::DEPTH-1:0]          cell_lt;
    logic [sal_pkg::DEPTH-1:0]          cell_hit;

    logic [sal_pkg::COUNT_W-1:0]        found_at;
    logic                               any_hit;

    assign cmd      = sal_pkg::cmd_t'(s_tuser);
    assign in_value = s_tdata[sal_pkg::VALUE_W-1:0];
    assign in_pos   = s_tdata[sal_pkg::VALUE_W +: sal_pkg::COUNT_W];
    assign accept   = s_tvalid && s_tready;

    assign s_tready  = (state_reg == sal_pkg::ST_IDLE);
    assign m_tvalid  = (state_reg == sal_pkg::ST_OUTPUT);
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    assign eff_cap = (sal_pkg::COUNT_W'(cap_reg) > DEPTH_C) ? DEPTH_C
                                                            : sal_pkg::COUNT_W'(cap_reg);

    // ------------------------------------------------------------------
    // Command decode: all cells update in the accept cycle. The count is
    // always at most DEPTH since inserts stop at the clipped capacity.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl.ins    = 1'b0;
        ctrl.rm     = 1'b0;
        ctrl.srch   = 1'b0;
        ctrl.rm_pos = '0;
        ctrl.count  = count_reg;
        ctrl.key    = in_value;
        count_next  = count_reg;
        ok_next     = ok_reg;

        if (accept)
        begin
            ok_next = 1'b0;
            unique case (cmd)
                sal_pkg::CMD_INSERT:
                begin
                    if (count_reg < eff_cap)
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                sal_pkg::CMD_REM_FIRST:
                begin
                    if (count_reg != '0)
                    begin
                        ctrl.rm    = 1'b1;
                        count_next = count_reg - 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                sal_pkg::CMD_REM_LAST:
                begin
                    // top slot just drops out of range
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                sal_pkg::CMD_REM_AT:
                begin
                    if ((in_pos != '0) && (in_pos <= count_reg))
                    begin
                        ctrl.rm     = 1'b1;
                        ctrl.rm_pos = in_pos - 1'b1;
                        count_next  = count_reg - 1'b1;
                        ok_next     = 1'b1;
                    end
                end
                sal_pkg::CMD_SEARCH:
                begin
                    // ok comes from the registered hit vector in the encode cycle
                    ctrl.srch = 1'b1;
                end
                sal_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                    ok_next    = 1'b1;
                end
                default:
                begin
                    // unused codes: no change, ok stays low
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: each cell sees its left and right neighbor
    // ------------------------------------------------------------------
    for (genvar i = 0; i < sal_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [sal_pkg::VALUE_W-1:0] left_value;
        logic signed [sal_pkg::VALUE_W-1:0] right_value;
        logic                               left_gt;
        logic                               left_lt;

        if (i == 0)
        begin : g_first
            assign left_value = in_value;
            assign left_gt    = 1'b0;
            assign left_lt    = 1'b1;
        end
        else
        begin : g_mid
            assign left_value = cell_value[i-1];
            assign left_gt    = cell_gt[i-1];
            assign left_lt    = cell_lt[i-1];
        end

        if (i == sal_pkg::DEPTH - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        sal_cell u_cell (
            .clk         (clk),
            .idx         (sal_pkg::COUNT_W'(i)),
            .ctrl        (ctrl),
            .left_value  (left_value),
            .left_gt     (left_gt),
            .left_lt     (left_lt),
            .right_value (right_value),
            .value       (cell_value[i]),
            .gt          (cell_gt[i]),
            .lt          (cell_lt[i]),
            .hit         (cell_hit[i])
        );
    end

    sal_encoder u_encoder (
        .hits     (cell_hit),
        .found_at (found_at),
        .any_hit  (any_hit)
    );

    // ------------------------------------------------------------------
    // Sequencer: accept -> encode hits -> hold result until taken
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sal_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = sal_pkg::ST_ENCODE;
            end
            sal_pkg::ST_ENCODE:
            begin
                state_next = sal_pkg::ST_OUTPUT;
            end
            sal_pkg::ST_OUTPUT:
            begin
                if (m_tready)
                    state_next = sal_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sal_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sal_pkg::ST_IDLE;
            count_reg <= '0;
            cap_reg   <= sal_pkg::CAP_W'(64);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    // result word, built in the encode cycle from the updated count
    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        if (state_reg == sal_pkg::ST_ENCODE)
        begin
            out_reg <= {7'd0,
                        (count_reg == '0),
                        (count_reg >= eff_cap),
                        count_reg,
                        found_at,
                        (ok_reg || any_hit)};
        end
    end

`ifndef SYNTHESIS
    // the count never runs past the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    // sorted order leaves at most one lower-bound hit
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_hit))
        else $error("more than one search hit");

    // one word in flight: no accept while a result is pending
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // result is presented once the encode state that follows the accept has passed
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("result not presented on time");
`endif

endmodule
